// ----- rtl/gle_pkg.sv -----
// shared types and constants of the gif lzw encoder
`timescale 1ns / 1ps

package gle_pkg;

    // dictionary geometry
    localparam int DICT_SIZE  = 4096;
    localparam int DICT_AW    = $clog2(DICT_SIZE);
    localparam int CODE_W     = 12;
    localparam int HASH_W     = 12;
    localparam int HASH_DEPTH = 1 << HASH_W;
    localparam int PIX_W      = 8;
    localparam int KEY_W      = CODE_W + PIX_W;
    localparam int ENTRY_W    = CODE_W + KEY_W;
    localparam int BYTE_W     = 8;
    localparam int SIZE_W     = 4;

    // code size limits
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 4'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 4'd8;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] pixel;
        logic       last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // request from the queue head to the back end
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_req;

endpackage

// ----- rtl/gle_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module gle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gle_front.sv -----
// front end: accepts pixel requests, masks the index, queues them for the back end
`timescale 1ns / 1ps

module gle_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [gle_pkg::SIZE_W-1:0]   i_size,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  gle_pkg::t_in_item            i_data,
    output gle_pkg::t_queue_req          o_q,
    input  logic                         i_pop
);

    gle_pkg::t_in_item                  r_mem [gle_pkg::QUEUE_DEPTH];
    logic [gle_pkg::QUEUE_AW-1:0]       r_wp, n_wp;
    logic [gle_pkg::QUEUE_AW-1:0]       r_rp, n_rp;
    logic [gle_pkg::QUEUE_AW:0]         r_cnt, n_cnt;
    logic                               w_push;
    logic [7:0]                         w_mask;
    gle_pkg::t_in_item                  w_item;

    // pixel mask from the code size
    assign w_mask = 8'((9'd1 << i_size) - 9'd1);

    always_comb begin
        w_item            = i_data;
        w_item.pixel      = i_data.pixel & w_mask;
    end

    assign o_ready = (r_cnt != (gle_pkg::QUEUE_AW+1)'(gle_pkg::QUEUE_DEPTH));
    assign w_push  = i_valid && o_ready;

    // queue pointers
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    assign o_q.valid = (r_cnt != '0);
    assign o_q.item  = r_mem[r_rp];

endmodule

// ----- rtl/gle_core.sv -----
// back end: dictionary search and insert, code packing and byte output
`timescale 1ns / 1ps

module gle_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gle_pkg::SIZE_W-1:0]   i_size,
    input  gle_pkg::t_queue_req          i_q,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output gle_pkg::t_out_item           o_data
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_HREAD   = 10'b0000000010,
        S_HEAD    = 10'b0000000100,
        S_PROBE   = 10'b0000001000,
        S_EMIT    = 10'b0000010000,
        S_INSERT  = 10'b0000100000,
        S_RESTART = 10'b0001000000,
        S_LASTCHK = 10'b0010000000,
        S_EOI     = 10'b0100000000,
        S_PAD     = 10'b1000000000
    } t_state;

    localparam int ACC_W = 19;
    localparam int CNT_W = 5;
    localparam int NF_W  = gle_pkg::CODE_W + 1;

    t_state                           r_state, n_state;
    t_state                           r_ret, n_ret;
    logic [7:0]                       r_pix, n_pix;
    logic                             r_last, n_last;
    logic [gle_pkg::CODE_W-1:0]       r_cur, n_cur;
    logic [NF_W-1:0]                  r_nf, n_nf;
    logic [3:0]                       r_width, n_width;
    logic [ACC_W-1:0]                 r_acc, n_acc;
    logic [CNT_W-1:0]                 r_n, n_n;
    logic                             r_started, n_started;
    logic                             r_final, n_final;
    logic [gle_pkg::CODE_W-1:0]       r_head, n_head;
    logic [gle_pkg::CODE_W-1:0]       r_probe, n_probe;
    logic                             r_ovalid, n_ovalid;
    gle_pkg::t_out_item               r_odata, n_odata;

    logic [8:0]                       w_clear;
    logic [gle_pkg::CODE_W-1:0]       w_first;
    logic [gle_pkg::KEY_W-1:0]        w_key;
    logic [gle_pkg::HASH_W-1:0]       w_hash;
    logic [gle_pkg::CODE_W-1:0]       w_head_rd;
    logic [gle_pkg::ENTRY_W-1:0]      w_dict_rd;
    logic [gle_pkg::CODE_W-1:0]       w_link;
    logic [gle_pkg::CODE_W-1:0]       w_dict_raddr;
    logic                             w_we;
    logic                             w_out_free;
    logic                             w_grow;
    logic [3:0]                       w_width_new;
    logic [NF_W-1:0]                  w_nf_inc;

    // append a code above the pending residue bits
    function automatic logic [ACC_W-1:0] put_acc(input logic [ACC_W-1:0] acc,
                                                 input logic [CNT_W-1:0] cnt,
                                                 input logic [gle_pkg::CODE_W-1:0] code);
        put_acc = acc | (ACC_W'(code) << cnt);
    endfunction

    // a code can be a live dictionary entry of the current table
    function automatic logic live(input logic [gle_pkg::CODE_W-1:0] c,
                                  input logic [gle_pkg::CODE_W-1:0] first,
                                  input logic [NF_W-1:0] nf);
        live = (c >= first) && ({1'b0, c} < nf);
    endfunction

    assign w_clear    = 9'd1 << i_size;
    assign w_first    = gle_pkg::CODE_W'(w_clear) + gle_pkg::CODE_W'(2);
    assign w_key      = {r_cur, r_pix};
    assign w_hash     = gle_pkg::HASH_W'(w_key ^ (w_key >> 12) ^ (w_key >> 7));
    assign w_link     = w_dict_rd[gle_pkg::ENTRY_W-1:gle_pkg::KEY_W];
    assign w_out_free = !r_ovalid || i_ready;
    assign w_grow     = (r_nf >> r_width) != '0;
    assign w_width_new = r_width + 4'(w_grow);
    assign w_nf_inc   = r_nf + 1'b1;

    // bucket heads, indexed by key hash
    gle_ram #(
        .WIDTH (gle_pkg::CODE_W),
        .DEPTH (gle_pkg::HASH_DEPTH)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_hash),
        .i_wdata (r_nf[gle_pkg::CODE_W-1:0]),
        .i_raddr (w_hash),
        .o_rdata (w_head_rd)
    );

    // dictionary entries: chain link and key per code
    gle_ram #(
        .WIDTH (gle_pkg::ENTRY_W),
        .DEPTH (gle_pkg::DICT_SIZE)
    ) u_dict_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_nf[gle_pkg::DICT_AW-1:0]),
        .i_wdata ({r_head, w_key}),
        .i_raddr (w_dict_raddr[gle_pkg::DICT_AW-1:0]),
        .o_rdata (w_dict_rd)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_pix        = r_pix;
        n_last       = r_last;
        n_cur        = r_cur;
        n_nf         = r_nf;
        n_width      = r_width;
        n_acc        = r_acc;
        n_n          = r_n;
        n_started    = r_started;
        n_final      = r_final;
        n_head       = r_head;
        n_probe      = r_probe;
        n_ovalid     = r_ovalid && !i_ready;
        n_odata      = r_odata;
        o_pop        = 1'b0;
        w_we         = 1'b0;
        w_dict_raddr = r_probe;

        case (r_state)
            S_IDLE: begin
                if (i_q.valid) begin
                    o_pop  = 1'b1;
                    n_pix  = i_q.item.pixel;
                    n_last = i_q.item.last_pixel;
                    if (!r_started) begin
                        // new stream: fresh table, clear code first
                        n_started = 1'b1;
                        n_cur     = gle_pkg::CODE_W'(i_q.item.pixel);
                        n_nf      = NF_W'(w_first);
                        n_width   = i_size + 4'd1;
                        n_acc     = ACC_W'(w_clear);
                        n_n       = CNT_W'(i_size) + 5'd1;
                        n_final   = 1'b0;
                        n_ret     = S_LASTCHK;
                        n_state   = S_EMIT;
                    end else begin
                        n_state = S_HREAD;
                    end
                end
            end
            S_HREAD: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_head = w_head_rd;
                if (live(w_head_rd, w_first, r_nf)) begin
                    w_dict_raddr = w_head_rd;
                    n_probe      = w_head_rd;
                    n_state      = S_PROBE;
                end else begin
                    n_acc   = put_acc(r_acc, r_n, r_cur);
                    n_n     = r_n + CNT_W'(r_width);
                    n_ret   = S_INSERT;
                    n_state = S_EMIT;
                end
            end
            S_PROBE: begin
                if (w_dict_rd[gle_pkg::KEY_W-1:0] == w_key) begin
                    n_cur   = r_probe;
                    n_state = S_LASTCHK;
                end else if (live(w_link, w_first, r_nf) && (w_link < r_probe)) begin
                    w_dict_raddr = w_link;
                    n_probe      = w_link;
                end else begin
                    n_acc   = put_acc(r_acc, r_n, r_cur);
                    n_n     = r_n + CNT_W'(r_width);
                    n_ret   = S_INSERT;
                    n_state = S_EMIT;
                end
            end
            S_INSERT: begin
                // add the new entry, grow width if the next code no longer fits
                w_we    = 1'b1;
                n_width = w_width_new;
                n_nf    = w_nf_inc;
                n_cur   = gle_pkg::CODE_W'(r_pix);
                if (w_nf_inc >= NF_W'(gle_pkg::DICT_SIZE)) begin
                    n_acc   = put_acc(r_acc, r_n, gle_pkg::CODE_W'(w_clear));
                    n_n     = r_n + CNT_W'(w_width_new);
                    n_ret   = S_RESTART;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LASTCHK;
                end
            end
            S_RESTART: begin
                n_nf    = NF_W'(w_first);
                n_width = i_size + 4'd1;
                n_state = S_LASTCHK;
            end
            S_LASTCHK: begin
                if (r_last) begin
                    n_acc   = put_acc(r_acc, r_n, r_cur);
                    n_n     = r_n + CNT_W'(r_width);
                    n_ret   = S_EOI;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EOI: begin
                n_final = 1'b1;
                n_acc   = put_acc(r_acc, r_n, gle_pkg::CODE_W'(w_clear) + 1'b1);
                n_n     = r_n + CNT_W'(r_width);
                n_ret   = S_PAD;
                n_state = S_EMIT;
            end
            S_PAD: begin
                // flush leftover bits as one zero padded byte
                if (r_n == '0) begin
                    n_started = 1'b0;
                    n_final   = 1'b0;
                    n_acc     = '0;
                    n_state   = S_IDLE;
                end else if (w_out_free) begin
                    n_ovalid          = 1'b1;
                    n_odata.out_byte  = r_acc[7:0];
                    n_odata.last_byte = 1'b1;
                    n_started         = 1'b0;
                    n_final           = 1'b0;
                    n_acc             = '0;
                    n_n               = '0;
                    n_state           = S_IDLE;
                end
            end
            S_EMIT: begin
                // one byte per cycle while eight or more bits wait and the output register is free
                if (r_n >= CNT_W'(gle_pkg::BYTE_W)) begin
                    if (w_out_free) begin
                        n_ovalid          = 1'b1;
                        n_odata.out_byte  = r_acc[7:0];
                        n_odata.last_byte = r_final && (r_n == CNT_W'(gle_pkg::BYTE_W));
                        n_acc             = r_acc >> gle_pkg::BYTE_W;
                        n_n               = r_n - CNT_W'(gle_pkg::BYTE_W);
                    end
                end else begin
                    n_acc   = r_acc & ACC_W'(7'h7f);
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a size write drops the stream in progress
        if (i_cfg_we) begin
            n_started = 1'b0;
            n_final   = 1'b0;
            n_acc     = '0;
            n_n       = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_started <= 1'b0;
            r_final   <= 1'b0;
            r_acc     <= '0;
            r_n       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_started <= n_started;
            r_final   <= n_final;
            r_acc     <= n_acc;
            r_n       <= n_n;
            r_ovalid  <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pix   <= n_pix;
        r_last  <= n_last;
        r_cur   <= n_cur;
        r_nf    <= n_nf;
        r_width <= n_width;
        r_head  <= n_head;
        r_probe <= n_probe;
        r_odata <= n_odata;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

// ----- rtl/gif_lzw_encoder_unit.sv -----
// top level of the gif lzw encoder
`timescale 1ns / 1ps

// GIF LZW encoder: takes one pixel index per request and returns the packed
// LSB-first code stream one byte per request, the final byte of a stream
// flagged. A pixel that hits the dictionary passes through queue pop, hash RAM
// address, bucket head read, one probe per dictionary entry along the bucket
// chain, and the last pixel check. A miss emits the bytes its code completes,
// leaves the byte loop and takes an insert step in place of the matching probe.
// The first pixel of a stream skips the lookup: pop, its clear code bytes, then
// the last pixel check. The last pixel adds the pending code, EOI and pad byte,
// leaving the byte loop after each code. The back end handles one pixel at a
// time; a two-entry queue in front takes new pixels while it works, and an
// output register holds a byte while the consumer stalls. Writing min_code_size
// restarts the stream and must be done only while the block is idle.
module gif_lzw_encoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gle_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  gle_pkg::t_in_item           i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output gle_pkg::t_out_item          o_data
);

    logic [gle_pkg::SIZE_W-1:0] r_min_size;
    logic [gle_pkg::SIZE_W-1:0] w_size;
    gle_pkg::t_queue_req        w_q;
    logic                       w_pop;

    // code size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_size <= gle_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_min_size <= i_cfg_data;
        end
    end

    // clamp the size to its legal range
    always_comb begin
        if (r_min_size < gle_pkg::SIZE_MIN) begin
            w_size = gle_pkg::SIZE_MIN;
        end else if (r_min_size > gle_pkg::SIZE_MAX) begin
            w_size = gle_pkg::SIZE_MAX;
        end else begin
            w_size = r_min_size;
        end
    end

    gle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (w_size),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_q     (w_q),
        .i_pop   (w_pop)
    );

    gle_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_size   (w_size),
        .i_q      (w_q),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

endmodule

// ----- dv/gle_checker.sv -----
// checker for the gif lzw encoder: predicts the byte stream and compares it
`timescale 1ns / 1ps

module gle_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gle_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    input  logic                        i_ready_in,
    input  gle_pkg::t_in_item           i_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  gle_pkg::t_out_item          i_out_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    // encoder state mirror
    logic [gle_pkg::SIZE_W-1:0] size_reg;
    int                         code_of_key[int];
    int                         pend_code;
    int                         free_code;
    int                         code_bits;
    int                         bit_acc;
    int                         bit_cnt;
    bit                         in_stream;
    gle_pkg::t_out_item         exp_bytes[$];
    gle_pkg::t_out_item         step_bytes[$];

    function automatic int size_eff();
        if (size_reg < gle_pkg::SIZE_MIN) return int'(gle_pkg::SIZE_MIN);
        if (size_reg > gle_pkg::SIZE_MAX) return int'(gle_pkg::SIZE_MAX);
        return int'(size_reg);
    endfunction

    task automatic restart_dict();
        code_of_key.delete();
        free_code = (1 << size_eff()) + 2;
        code_bits = size_eff() + 1;
    endtask

    task automatic restart_stream();
        restart_dict();
        pend_code = 0;
        bit_acc   = 0;
        bit_cnt   = 0;
        in_stream = 0;
    endtask

    // pack one code lsb first, collecting whole bytes
    task automatic pack_code(input int code);
        int acc;
        int n;
        gle_pkg::t_out_item b;
        acc = bit_acc | ((code & 12'hFFF) << bit_cnt);
        n   = bit_cnt + code_bits;
        while (n >= gle_pkg::BYTE_W) begin
            b.out_byte  = acc[7:0];
            b.last_byte = 1'b0;
            step_bytes  = {step_bytes, b};
            acc = acc >> gle_pkg::BYTE_W;
            n   = n - gle_pkg::BYTE_W;
        end
        bit_acc = acc & 8'h7F;
        bit_cnt = n;
    endtask

    // expected bytes for one accepted pixel request
    task automatic predict_pixel(input gle_pkg::t_in_item req);
        int                 clr;
        int                 pix;
        int                 key;
        gle_pkg::t_out_item b;
        clr = 1 << size_eff();
        pix = req.pixel & (clr - 1);
        step_bytes.delete();
        if (!in_stream) begin
            in_stream = 1;
            pack_code(clr);
            pend_code = pix;
        end else begin
            key = ((pend_code & 12'hFFF) << 8) | pix;
            if (code_of_key.exists(key)) begin
                pend_code = code_of_key[key];
            end else begin
                pack_code(pend_code);
                if ((free_code >> code_bits) != 0) code_bits++;
                if (free_code < gle_pkg::DICT_SIZE) code_of_key[key] = free_code;
                free_code++;
                if (free_code >= gle_pkg::DICT_SIZE) begin
                    pack_code(clr);
                    restart_dict();
                end
                pend_code = pix;
            end
        end
        if (req.last_pixel) begin
            pack_code(pend_code);
            pack_code(clr + 1);
            if (bit_cnt > 0) begin
                b.out_byte  = bit_acc[7:0];
                b.last_byte = 1'b0;
                step_bytes  = {step_bytes, b};
            end
            if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last_byte = 1'b1;
            restart_stream();
        end
        exp_bytes = {exp_bytes, step_bytes};
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        gle_pkg::t_out_item want;
        if (!i_rst_n) begin
            size_reg = gle_pkg::SIZE_RESET;
            restart_stream();
            exp_bytes.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (exp_bytes.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("unexpected byte %02h last %0b",
                                 i_out_data.out_byte, i_out_data.last_byte);
                end else begin
                    want = exp_bytes.pop_front();
                    if (want.out_byte !== i_out_data.out_byte ||
                        want.last_byte !== i_out_data.last_byte) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display("byte mismatch: exp %02h/%0b got %02h/%0b",
                                     want.out_byte, want.last_byte,
                                     i_out_data.out_byte, i_out_data.last_byte);
                    end
                end
            end
            if (i_cfg_we) begin
                size_reg = i_cfg_data;
                restart_stream();
            end
            if (i_valid && i_ready_in) predict_pixel(i_data);
        end
        o_pending = exp_bytes.size();
    end

endmodule

// ----- dv/tb_gif_lzw_encoder_unit.sv -----
// testbench top for the gif lzw encoder: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_gif_lzw_encoder_unit;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [gle_pkg::SIZE_W-1:0] i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    gle_pkg::t_in_item          i_data = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    gle_pkg::t_out_item         o_data;

    int                  fail_count;
    int                  bytes_owed;
    int                  tx_idle_pct = 0;
    int                  rx_stall_pct = 0;
    logic                hold_go = 1'b0;
    int                  hold_left = 0;
    int                  cycle_cnt = 0;

    gif_lzw_encoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    gle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_ready_in   (o_ready),
        .i_data       (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (bytes_owed)
    );

    always #10 i_clk = ~i_clk;

    // byte consumer with random stalls and an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("gif_lzw_encoder_unit verification failed");
            $finish;
        end
    end

    // offer one pixel request and wait for it to be taken
    task automatic send_pixel(input logic [7:0] pix, input logic fin);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{pixel: pix, last_pixel: fin};
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // pause until every byte is out and the back end has settled
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (bytes_owed != 0) @(negedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [gle_pkg::SIZE_W-1:0] sz);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sz;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // one image stream; alphabet narrowed now and then so strings repeat
    task automatic send_stream(input int len, input bit terminate);
        logic [7:0] mask;
        mask = ($urandom_range(2) == 0) ? 8'h01 : 8'($urandom());
        for (int k = 0; k < len; k++)
            send_pixel(8'($urandom()) & (($urandom_range(3) == 0) ? 8'hFF : mask),
                       terminate && (k == len - 1));
    endtask

    initial begin
        logic [gle_pkg::SIZE_W-1:0] sizes[4];
        int idles[4];
        int stalls[4];
        sizes  = '{4'd1, 4'd15, 4'd3, 4'd0};
        idles  = '{0, 75, 0, 36};
        stalls = '{0, 0, 75, 36};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset size, extremes, single pixel streams, repeats
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);
        for (int k = 0; k < 8; k++) send_pixel(8'h00, k == 7);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b1);
        write_size(4'd1);
        for (int k = 0; k < 6; k++) send_pixel(8'hFE | k[0], k == 5);
        send_pixel(8'h03, 1'b0);
        write_size(4'd8);
        // wide random stream at full size
        for (int k = 0; k < 40; k++) send_pixel(8'($urandom()), k == 39);
        wait_drained();

        // random phases under different idling
        for (int ph = 0; ph < 4; ph++) begin
            write_size(sizes[ph]);
            tx_idle_pct  = idles[ph];
            rx_stall_pct = stalls[ph];
            if (ph == 0) begin
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            for (int n = 0; n < 80; ) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
                send_stream(len, $urandom_range(9) != 0);
                n += len;
            end
            if (ph == 1) wait_drained();
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
        end
        write_size(4'd2);
        send_stream(30, 1'b1);
        write_size(4'd8);
        send_stream(20, 1'b1);

        wait_drained();
        if (fail_count == 0)
            $display("gif_lzw_encoder_unit verification clean");
        else
            $display("gif_lzw_encoder_unit verification failed");
        $finish;
    end

endmodule
